@@ hw/rtl/umef_pkg.sv @@
// Shared types and constants for the ultrasonic median / moving-average filter.
package umef_pkg;

    localparam int ECHO_W    = 16;  // echo time, us
    localparam int DIST_W    = 12;  // distance and register width, mm
    localparam int MM_W      = 14;  // raw converted distance, up to 11300 mm
    localparam int VS_W      = 4;   // valid sample count field
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 16;  // prev*7 + median*3, up to 40950

    // (us*10+29)/58 = floor(floor(x/2)/29), reciprocal of 29 scaled by 2^24
    localparam int        CONV_W     = 20;
    localparam int        DIV29_SH   = 24;
    localparam logic [19:0] DIV29_MUL = 20'd578525;
    localparam logic [19:0] ECHO_SCALE = 20'd10;
    localparam logic [19:0] ECHO_BIAS  = 20'd29;

    // x/10 for x < 2^16, reciprocal scaled by 2^19
    localparam int        DIV10_SH  = 19;
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam logic [15:0] PREV_WT   = 16'd7;
    localparam logic [15:0] MED_WT    = 16'd3;

    localparam logic [DIST_W-1:0] MIN_RST  = 12'd20;
    localparam logic [DIST_W-1:0] MAX_RST  = 12'd4000;
    localparam logic [DIST_W-1:0] JUMP_RST = 12'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN  = 2'd0,
        CFG_MAX  = 2'd1,
        CFG_JUMP = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_INS,
        S_RANK,
        S_PICK,
        S_JUMP,
        S_SUM,
        S_DIV
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic            ins;
        logic            clr;
        logic [MM_W-1:0] x;
    } t_bcast;

    // What one cell shows to its right-hand neighbor.
    typedef struct packed {
        logic            valid;
        logic [MM_W-1:0] value;
        logic            greater;
    } t_link;

    // Evaluation flags of one cell.
    typedef struct packed {
        logic in_range;
        logic below;
    } t_flag;

    localparam t_link LINK_HEAD = '{valid: 1'b1, value: '0, greater: 1'b0};

endpackage

@@ hw/rtl/umef_cell.sv @@
// One slot of the sorted insertion chain, with its range-gate flags.
module umef_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  umef_pkg::t_bcast                 i_bc,
    input  umef_pkg::t_link                  i_left,
    input  logic [umef_pkg::DIST_W-1:0]      i_min,
    input  logic [umef_pkg::DIST_W-1:0]      i_max,
    output umef_pkg::t_link                  o_link,
    output umef_pkg::t_flag                  o_flag
);
    import umef_pkg::*;

    logic            r_valid;
    logic [MM_W-1:0] r_value;
    logic            n_valid;
    logic [MM_W-1:0] n_value;
    logic            w_eff_valid;
    logic            w_greater;

    assign w_eff_valid = r_valid && !i_bc.clr;
    assign w_greater   = !w_eff_valid || (r_value > i_bc.x);

    always_comb begin
        n_valid = w_eff_valid;
        n_value = r_value;
        if (i_bc.ins && w_greater) begin
            if (i_left.greater) begin
                // shift the larger neighbor one slot right
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_bc.x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link.valid   = w_eff_valid;
    assign o_link.value   = r_value;
    assign o_link.greater = w_greater;

    assign o_flag.below    = r_valid && (r_value < MM_W'(i_min));
    assign o_flag.in_range = r_valid && (r_value >= MM_W'(i_min))
                             && (r_value <= MM_W'(i_max));

endmodule

@@ hw/rtl/ultrasonic_median_ema_filter.sv @@
// Top level of the ultrasonic median / moving-average distance filter.
//
// Each request carries one echo time in microseconds (0 = no echo). Every
// nonzero echo is converted to millimeters as (us*10+29)/58 and inserted into
// a row of SAMPLES sorting cells, so the chain always holds the batch in
// ascending order. After SAMPLES requests the batch is evaluated: each cell
// flags itself against the min/max window, the kept values form one run of
// the chain, and the upper median is read from the cell at offset
// (count below min) + kept/2. A median that moves more than the jump limit
// away from a nonzero previous output is replaced by that output; the result
// is then (previous*7 + median*3)/10, or the median itself when there is no
// previous output. With no kept sample the previous output is repeated with
// a zero count. Each request is registered, converted through the reciprocal
// multiplier and inserted into the chain; the request that closes a batch
// then goes through rank, pick, jump check, weighted sum and divide by 10.
// No new request is taken until this work is done. Results sit in an output
// register, so the next request is taken while a result waits; a batch end
// only stalls if the previous result is still waiting. Configuration writes
// are always ready; indexes beyond the register list are dropped.
module ultrasonic_median_ema_filter #(
    parameter int SAMPLES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // echo requests
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [umef_pkg::ECHO_W-1:0]         i_echo_time_us,
    // filtered results
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [umef_pkg::DIST_W-1:0]         o_distance_mm,
    output logic [umef_pkg::VS_W-1:0]           o_valid_samples,
    output logic                                o_jump_rejected,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [umef_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [umef_pkg::DIST_W-1:0]         i_cfg_data
);
    import umef_pkg::*;

    localparam int CW = $clog2(SAMPLES + 1);
    localparam int IW = $clog2(SAMPLES);
    localparam logic [CW-1:0] LAST = CW'(SAMPLES - 1);

    // configuration
    logic [DIST_W-1:0] r_min;
    logic [DIST_W-1:0] r_max;
    logic [DIST_W-1:0] r_jump;

    // control
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [DIST_W-1:0] r_prev;

    // datapath
    logic [ECHO_W-1:0] r_echo;
    logic [MM_W-1:0]   r_mm;
    logic              r_nz;
    logic [CW-1:0]     r_n;
    logic [IW-1:0]     r_idx;
    logic [DIST_W-1:0] r_med;
    logic [DIST_W-1:0] r_sel;
    logic              r_rej;
    logic [SUM_W-1:0]  r_sum;

    // output register
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic [VS_W-1:0]   r_out_cnt;
    logic              r_out_rej;

    logic              w_accept;
    logic              w_out_free;
    logic              w_load;

    logic [CONV_W-1:0]        w_conv_x;
    logic [CONV_W-2:0]        w_conv_y;
    logic [2*CONV_W-2:0]      w_conv_prod;
    logic [2*SUM_W-1:0]       w_div_prod;
    logic [DIST_W-1:0]        w_avg;
    logic [DIST_W-1:0]        w_result;
    logic [DIST_W-1:0]        w_diff;

    logic [CW-1:0]            w_kept;
    logic [CW-1:0]            w_low;
    logic [CW-1:0]            w_pos;

    t_bcast                   w_bc;
    t_link                    w_link [SAMPLES];
    t_flag                    w_flag [SAMPLES];

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = (r_state == S_DIV) && w_out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_RST;
            r_max  <= MAX_RST;
            r_jump <= JUMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN:  r_min  <= i_cfg_data;
                CFG_MAX:  r_max  <= i_cfg_data;
                CFG_JUMP: r_jump <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Echo to millimeters: us*10+29, halve, then multiply by the reciprocal of 29
    // ---------------------------------------------------------------------
    assign w_conv_x    = CONV_W'(r_echo) * ECHO_SCALE + ECHO_BIAS;
    assign w_conv_y    = w_conv_x[CONV_W-1:1];
    assign w_conv_prod = (2*CONV_W-1)'(w_conv_y) * (2*CONV_W-1)'(DIV29_MUL);

    // ---------------------------------------------------------------------
    // Sorting chain: insert on the INS cycle, clear at the start of a batch
    // ---------------------------------------------------------------------
    assign w_bc.ins = (r_state == S_INS) && r_nz;
    assign w_bc.clr = (r_state == S_INS) && (r_count == '0);
    assign w_bc.x   = r_mm;

    for (genvar k = 0; k < SAMPLES; k++) begin : g_cell
        umef_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bc   (w_bc),
            .i_left ((k == 0) ? LINK_HEAD : w_link[(k == 0) ? 0 : k - 1]),
            .i_min  (r_min),
            .i_max  (r_max),
            .o_link (w_link[k]),
            .o_flag (w_flag[k])
        );
    end

    // kept values are one run of the sorted chain, starting after the
    // values that fall below the window
    always_comb begin
        w_kept = '0;
        w_low  = '0;
        for (int k = 0; k < SAMPLES; k++) begin
            w_kept = w_kept + CW'(w_flag[k].in_range);
            w_low  = w_low + CW'(w_flag[k].below);
        end
        w_pos = w_low + (w_kept >> 1);
    end

    // ---------------------------------------------------------------------
    // Jump check and weighted average
    // ---------------------------------------------------------------------
    assign w_diff = (r_med > r_prev) ? (r_med - r_prev) : (r_prev - r_med);

    assign w_div_prod = (2*SUM_W)'(r_sum) * (2*SUM_W)'(DIV10_MUL);
    assign w_avg      = w_div_prod[DIV10_SH +: DIST_W];

    always_comb begin
        if (r_n == '0) begin
            w_result = r_prev;
        end else if (r_prev == '0) begin
            w_result = r_med;
        end else begin
            w_result = w_avg;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CONV;
            end
            S_CONV: n_state = S_INS;
            S_INS: begin
                n_state = (r_count == LAST) ? S_RANK : S_IDLE;
            end
            S_RANK: n_state = S_PICK;
            S_PICK: n_state = S_JUMP;
            S_JUMP: n_state = S_SUM;
            S_SUM:  n_state = S_DIV;
            S_DIV: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // batch position and previous output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
        end else begin
            if (r_state == S_INS) begin
                r_count <= (r_count == LAST) ? '0 : r_count + CW'(1);
            end
            if (w_load) begin
                r_prev <= w_result;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_echo <= i_echo_time_us;
        end
        if (r_state == S_CONV) begin
            r_mm <= w_conv_prod[DIV29_SH +: MM_W];
            r_nz <= (r_echo != '0);
        end
        if (r_state == S_RANK) begin
            r_n   <= w_kept;
            r_idx <= w_pos[IW-1:0];
        end
        if (r_state == S_PICK) begin
            r_med <= w_link[r_idx].value[DIST_W-1:0];
        end
        if (r_state == S_JUMP) begin
            // swap in the previous output when the median jumps too far
            r_rej <= (r_prev != '0) && (w_diff > r_jump);
            r_sel <= ((r_prev != '0) && (w_diff > r_jump)) ? r_prev : r_med;
        end
        if (r_state == S_SUM) begin
            r_sum <= SUM_W'(r_prev) * PREV_WT + SUM_W'(r_sel) * MED_WT;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: hold until taken, refill on the same edge
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_dist <= w_result;
            r_out_cnt  <= VS_W'(r_n);
            r_out_rej  <= (r_n != '0) && r_rej;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_distance_mm   = r_out_dist;
    assign o_valid_samples = r_out_cnt;
    assign o_jump_rejected = r_out_rej;

endmodule
